[src/skaf_pkg.sv]
package skaf_pkg;

  localparam int unsigned SampleW   = 16;  // rate, measure and angle width
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned CovW      = 24;
  localparam int unsigned PcovW     = CovW + 1;   // error_cov + q
  localparam int unsigned DenomW    = CovW + 2;   // error_cov + q + r
  localparam int unsigned GainW     = 16;
  localparam int unsigned QuotW     = GainW + 1;  // quotient may reach 2^16
  localparam int unsigned PredW     = 22;
  localparam int unsigned InnovW    = PredW + 1;
  localparam int unsigned MulW      = 26;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned DivCntW   = 5;
  localparam logic [DivCntW-1:0] DivSteps = DivCntW'(QuotW);

  localparam logic [PeriodW-1:0] SamplePeriodRst    = 16'd131;
  localparam logic [CovW-1:0]    ProcessNoiseRst    = 24'd1049;
  localparam logic [CovW-1:0]    MeasureNoiseRst    = 24'd524288;
  localparam logic [CovW-1:0]    StartCovarianceRst = 24'd1048576;

  localparam logic [CfgIndexW-1:0] CFG_SAMPLE_PERIOD    = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_PROCESS_NOISE    = 8'd1;
  localparam logic [CfgIndexW-1:0] CFG_MEASURE_NOISE    = 8'd2;
  localparam logic [CfgIndexW-1:0] CFG_START_COVARIANCE = 8'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MRATE,
    S_PRED,
    S_DIV,
    S_MGAIN,
    S_CORR,
    S_MCOV,
    S_DONE
  } skaf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skaf_div_stat_t;

endpackage

[src/skaf_divider.sv]
// Restoring divider, one quotient bit per cycle. Yields the saturated gain
// floor(dividend * 2^16 / divisor), forced to zero for a zero divisor.
module skaf_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [skaf_pkg::PcovW-1:0]         dividend,
  input  logic [skaf_pkg::DenomW-1:0]        divisor,
  output skaf_pkg::skaf_div_stat_t           stat,
  output logic [skaf_pkg::GainW-1:0]         gain
);

  logic                             busy_r;
  logic                             done_r;
  logic [skaf_pkg::DivCntW-1:0]     cnt_r;
  logic [skaf_pkg::DenomW:0]        rem_r;
  logic [skaf_pkg::DenomW-1:0]      den_r;
  logic [skaf_pkg::QuotW-1:0]       quot_r;

  logic [skaf_pkg::DenomW+1:0]      diff;
  logic                             qbit;
  logic [skaf_pkg::DenomW:0]        rem_sel;

  always_comb begin
    diff    = {1'b0, rem_r} - {2'b00, den_r};
    qbit    = ~diff[skaf_pkg::DenomW+1];
    rem_sel = qbit ? diff[skaf_pkg::DenomW:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= skaf_pkg::DivSteps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == skaf_pkg::DivCntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, dividend};
      den_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops safely
      rem_r  <= {rem_sel[skaf_pkg::DenomW-1:0], 1'b0};
      quot_r <= {quot_r[skaf_pkg::QuotW-2:0], qbit};
    end
  end

  always_comb begin
    stat.busy = busy_r;
    stat.done = done_r;
    if (den_r == '0) begin
      gain = '0;
    end else if (quot_r[skaf_pkg::QuotW-1]) begin
      gain = '1;
    end else begin
      gain = quot_r[skaf_pkg::GainW-1:0];
    end
  end

endmodule

[src/scalar_kalman_angle_filter.sv]
// One input at a time: in_stall is low only in the idle state, entered once the
// previous result is committed. A 17-step serial divider forms the gain, and one
// shared 26x26 multiplier serves rate, correction and covariance products in turn.
// A finished result waits in the output register while the next input is taken.
// Reset (synchronous, rst_n low) restores register defaults, clears the angle
// and the primed flag; covariance reloads from start_covariance on the next input.
module scalar_kalman_angle_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [skaf_pkg::SampleW-1:0] in_rate_sample,
  input  logic signed [skaf_pkg::SampleW-1:0] in_tilt_measure,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [skaf_pkg::SampleW-1:0] out_tilt_estimate,
  input  logic                               cfg_wr_en,
  input  logic [skaf_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [skaf_pkg::CfgDataW-1:0]      cfg_wr_data
);

  // configuration
  logic [skaf_pkg::PeriodW-1:0] sample_period_r;
  logic [skaf_pkg::CovW-1:0]    process_noise_r;
  logic [skaf_pkg::CovW-1:0]    measure_noise_r;
  logic [skaf_pkg::CovW-1:0]    start_cov_r;

  // filter state and per-item working registers
  skaf_pkg::skaf_state_t             state_r, state_nxt;
  logic                              primed_r;
  logic signed [skaf_pkg::SampleW-1:0] angle_r;
  logic [skaf_pkg::CovW-1:0]         cov_r;
  logic signed [skaf_pkg::SampleW-1:0] rate_r;
  logic signed [skaf_pkg::SampleW-1:0] meas_r;
  logic [skaf_pkg::PcovW-1:0]        pcov_r;
  logic signed [skaf_pkg::PredW-1:0] pred_r;
  logic [skaf_pkg::GainW-1:0]        gain_r;
  logic signed [skaf_pkg::SampleW-1:0] next_angle_r;
  logic signed [skaf_pkg::ProdW-1:0] prod_r;
  logic                              out_valid_r;
  logic signed [skaf_pkg::SampleW-1:0] out_r;

  // control
  logic in_xfer;
  logic out_free;
  logic div_start;
  logic ld_prod;
  logic commit;
  logic signed [skaf_pkg::MulW-1:0] mul_a, mul_b;

  // datapath intermediates
  logic [skaf_pkg::DenomW-1:0]        denom;
  logic signed [skaf_pkg::ProdW-1:0]  rnd12, rnd16;
  logic signed [skaf_pkg::PredW-1:0]  pred_sum;
  logic signed [skaf_pkg::InnovW-1:0] innov;
  logic signed [skaf_pkg::PredW+3:0]  next_sum;
  logic signed [skaf_pkg::SampleW-1:0] next_sat;
  logic [skaf_pkg::QuotW-1:0]         cov_gain;
  logic [41:0]                        cov_sum;
  logic [skaf_pkg::CovW-1:0]          ncov;

  skaf_pkg::skaf_div_stat_t    div_stat;
  logic [skaf_pkg::GainW-1:0]  div_gain;

  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign out_valid         = out_valid_r;
  assign out_tilt_estimate = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= skaf_pkg::SamplePeriodRst;
      process_noise_r <= skaf_pkg::ProcessNoiseRst;
      measure_noise_r <= skaf_pkg::MeasureNoiseRst;
      start_cov_r     <= skaf_pkg::StartCovarianceRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        skaf_pkg::CFG_SAMPLE_PERIOD:
          sample_period_r <= cfg_wr_data[skaf_pkg::PeriodW-1:0];
        skaf_pkg::CFG_PROCESS_NOISE:    process_noise_r <= cfg_wr_data;
        skaf_pkg::CFG_MEASURE_NOISE:    measure_noise_r <= cfg_wr_data;
        skaf_pkg::CFG_START_COVARIANCE: start_cov_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skaf_pkg::S_IDLE:  if (in_valid) state_nxt = skaf_pkg::S_MRATE;
      skaf_pkg::S_MRATE: state_nxt = skaf_pkg::S_PRED;
      skaf_pkg::S_PRED:  state_nxt = skaf_pkg::S_DIV;
      skaf_pkg::S_DIV:   if (div_stat.done) state_nxt = skaf_pkg::S_MGAIN;
      skaf_pkg::S_MGAIN: state_nxt = skaf_pkg::S_CORR;
      skaf_pkg::S_CORR:  state_nxt = skaf_pkg::S_MCOV;
      skaf_pkg::S_MCOV:  state_nxt = skaf_pkg::S_DONE;
      skaf_pkg::S_DONE:  if (out_free) state_nxt = skaf_pkg::S_IDLE;
      default:           state_nxt = skaf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs, including multiplier operand select
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    ld_prod   = 1'b0;
    commit    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      skaf_pkg::S_IDLE: in_stall = 1'b0;
      skaf_pkg::S_MRATE: begin
        ld_prod = 1'b1;
        mul_a   = {{(skaf_pkg::MulW-skaf_pkg::SampleW){rate_r[skaf_pkg::SampleW-1]}}, rate_r};
        mul_b   = {{(skaf_pkg::MulW-skaf_pkg::PeriodW){1'b0}}, sample_period_r};
      end
      skaf_pkg::S_PRED: div_start = 1'b1;
      skaf_pkg::S_MGAIN: begin
        ld_prod = 1'b1;
        mul_a   = {{(skaf_pkg::MulW-skaf_pkg::GainW){1'b0}}, gain_r};
        mul_b   = {{(skaf_pkg::MulW-skaf_pkg::InnovW){innov[skaf_pkg::InnovW-1]}}, innov};
      end
      skaf_pkg::S_MCOV: begin
        ld_prod = 1'b1;
        mul_a   = {{(skaf_pkg::MulW-skaf_pkg::QuotW){1'b0}}, cov_gain};
        mul_b   = {{(skaf_pkg::MulW-skaf_pkg::PcovW){1'b0}}, pcov_r};
      end
      skaf_pkg::S_DONE: commit = out_free;
      default: ;
    endcase
  end

  // arithmetic around the shared multiplier
  always_comb begin
    denom    = {1'b0, pcov_r} + {2'b00, measure_noise_r};
    rnd12    = (prod_r + skaf_pkg::ProdW'(2048)) >>> 12;
    pred_sum = rnd12[skaf_pkg::PredW-1:0]
             + {{(skaf_pkg::PredW-skaf_pkg::SampleW){angle_r[skaf_pkg::SampleW-1]}}, angle_r};
    innov    = {{(skaf_pkg::InnovW-skaf_pkg::SampleW){meas_r[skaf_pkg::SampleW-1]}}, meas_r}
             - {pred_r[skaf_pkg::PredW-1], pred_r};
    rnd16    = (prod_r + skaf_pkg::ProdW'(32768)) >>> 16;
    next_sum = rnd16[skaf_pkg::PredW+3:0] + {{4{pred_r[skaf_pkg::PredW-1]}}, pred_r};
    if (next_sum > 26'sd32767) begin
      next_sat = 16'sh7fff;
    end else if (next_sum < -26'sd32768) begin
      next_sat = 16'sh8000;
    end else begin
      next_sat = next_sum[skaf_pkg::SampleW-1:0];
    end
    cov_gain = 17'h10000 - {1'b0, gain_r};
    cov_sum  = prod_r[41:0] + 42'd32768;
    ncov     = (|cov_sum[41:40]) ? '1 : cov_sum[39:16];
  end

  skaf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pcov_r),
    .divisor  (denom),
    .stat     (div_stat),
    .gain     (div_gain)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skaf_pkg::S_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) primed_r <= 1'b1;
      if (commit) begin
        out_valid_r <= 1'b1;
        angle_r     <= next_angle_r;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rate_r <= in_rate_sample;
      meas_r <= in_tilt_measure;
      if (!primed_r) cov_r <= start_cov_r;
    end
    if (state_r == skaf_pkg::S_MRATE) pcov_r <= {1'b0, cov_r} + {1'b0, process_noise_r};
    if (ld_prod) prod_r <= mul_a * mul_b;
    if (state_r == skaf_pkg::S_PRED) pred_r <= pred_sum;
    if (div_stat.done) gain_r <= div_gain;
    if (state_r == skaf_pkg::S_CORR) next_angle_r <= next_sat;
    if (commit) begin
      cov_r <= ncov;
      out_r <= next_angle_r;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == skaf_pkg::S_DIV)
    else $error("divider finished outside its wait state");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skaf_pkg::S_IDLE |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == skaf_pkg::S_DONE)
    else $error("result raised outside the final step");

  a_primed_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> primed_r)
    else $error("primed flag not set after an input transfer");
`endif

endmodule
